/* hw/rtl/sbac_pkg.sv */
package sbac_pkg;

  // default geometry
  localparam int COUNT_WIDTH_DEF    = 16;
  localparam int POSITION_WIDTH_DEF = 10;

  // motor controller addresses
  localparam logic [7:0] STEER_ADDR = 8'd128;
  localparam logic [7:0] BRAKE_ADDR = 8'd130;

  // channel slots in the last-command table
  localparam logic CH_STEER = 1'b0;
  localparam logic CH_BRAKE = 1'b1;

  // packet queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // configuration
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 15;

  typedef enum logic [CFG_AW-1:0] {
    CFG_LINK_READY  = 3'd0,
    CFG_DEADBAND    = 3'd1,
    CFG_STEER_RATE  = 3'd2,
    CFG_BRAKE_RATE  = 3'd3,
    CFG_STEER_LIMIT = 3'd4,
    CFG_BRAKE_MIN   = 3'd5,
    CFG_BRAKE_MAX   = 3'd6
  } cfg_idx_e;

  localparam logic        RST_LINK_READY  = 1'b0;
  localparam logic [7:0]  RST_DEADBAND    = 8'd20;
  localparam logic [6:0]  RST_STEER_RATE  = 7'd80;
  localparam logic [6:0]  RST_BRAKE_RATE  = 7'd120;
  localparam logic [14:0] RST_STEER_LIMIT = 15'd2300;
  localparam logic [9:0]  RST_BRAKE_MIN   = 10'd100;
  localparam logic [9:0]  RST_BRAKE_MAX   = 10'd900;

  typedef struct packed {
    logic        link_ready;
    logic [7:0]  deadband;
    logic [6:0]  steer_rate;
    logic [6:0]  brake_rate;
    logic [14:0] steer_limit;
    logic [9:0]  brake_min;
    logic [9:0]  brake_max;
  } cfg_t;

  // one motor packet
  typedef struct packed {
    logic [7:0] addr;
    logic       dir;
    logic [6:0] speed;
    logic [6:0] cks;
    logic       last;
  } pkt_t;

  // up to two packets handed to the queue in one cycle
  typedef struct packed {
    logic [1:0] n;
    pkt_t       p0;
    pkt_t       p1;
  } push_t;

  // cmd is {dir, speed}
  function automatic pkt_t mk_pkt(input logic [7:0] addr, input logic [7:0] cmd,
                                  input logic last);
    pkt_t       p;
    logic [7:0] sum;
    sum     = addr + {7'd0, cmd[7]} + {1'b0, cmd[6:0]};
    p.addr  = addr;
    p.dir   = cmd[7];
    p.speed = cmd[6:0];
    p.cks   = sum[6:0];
    p.last  = last;
    return p;
  endfunction

endpackage

/* hw/rtl/sbac_cfg.sv */
module sbac_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sbac_pkg::CFG_AW-1:0]       cfg_idx_i,
  input  logic [sbac_pkg::CFG_DW-1:0]       cfg_wdata_i,
  output sbac_pkg::cfg_t                    cfg_o
);

  sbac_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sbac_pkg::CFG_LINK_READY:  cfg_d.link_ready  = cfg_wdata_i[0];
        sbac_pkg::CFG_DEADBAND:    cfg_d.deadband    = cfg_wdata_i[7:0];
        sbac_pkg::CFG_STEER_RATE:  cfg_d.steer_rate  = cfg_wdata_i[6:0];
        sbac_pkg::CFG_BRAKE_RATE:  cfg_d.brake_rate  = cfg_wdata_i[6:0];
        sbac_pkg::CFG_STEER_LIMIT: cfg_d.steer_limit = cfg_wdata_i[14:0];
        sbac_pkg::CFG_BRAKE_MIN:   cfg_d.brake_min   = cfg_wdata_i[9:0];
        sbac_pkg::CFG_BRAKE_MAX:   cfg_d.brake_max   = cfg_wdata_i[9:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.link_ready  <= sbac_pkg::RST_LINK_READY;
      cfg_q.deadband    <= sbac_pkg::RST_DEADBAND;
      cfg_q.steer_rate  <= sbac_pkg::RST_STEER_RATE;
      cfg_q.brake_rate  <= sbac_pkg::RST_BRAKE_RATE;
      cfg_q.steer_limit <= sbac_pkg::RST_STEER_LIMIT;
      cfg_q.brake_min   <= sbac_pkg::RST_BRAKE_MIN;
      cfg_q.brake_max   <= sbac_pkg::RST_BRAKE_MAX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/sbac_core.sv */
module sbac_core #(
  parameter int COUNT_WIDTH    = sbac_pkg::COUNT_WIDTH_DEF,
  parameter int POSITION_WIDTH = sbac_pkg::POSITION_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sbac_pkg::cfg_t            cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                encoder_pins_i,
  input  logic [POSITION_WIDTH-1:0] brake_position_i,
  input  logic                      estop_active_i,
  input  logic                      steer_target_valid_i,
  input  logic signed [15:0]        steer_target_i,
  input  logic                      brake_target_valid_i,
  input  logic signed [15:0]        brake_target_i,
  input  logic                      zero_steering_i,
  input  logic                      space_i,
  output sbac_pkg::push_t           push_o
);

  localparam int CW = COUNT_WIDTH;
  localparam int PW = POSITION_WIDTH;
  localparam int SW = ((CW > 16) ? CW : 16) + 2;       // steer clamp width
  localparam int BW = 18;                              // brake clamp width
  localparam int ES = ((CW > PW) ? CW : PW) + 2;       // error width

  localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [PW-1:0]        POS_MAX = {PW{1'b1}};

  // input register
  logic                 vld_q, vld_d;
  logic [1:0]           enc_q;
  logic [PW-1:0]        pos_q;
  logic                 estop_q, stv_q, btv_q, zero_q;
  logic signed [15:0]   st_q, bt_q;

  // block state
  logic [1:0]           prev_q;
  logic signed [CW-1:0] cnt_q, cnt_d;
  logic signed [CW-1:0] ssp_q, ssp_d;
  logic [PW-1:0]        bsp_q, bsp_d;
  logic [7:0]           lcmd_q [2];

  logic                 ld, fire;
  logic [3:0]           trans;
  logic                 step_dn, step_up;
  logic signed [SW-1:0] sv, slim;
  logic signed [BW-1:0] bv;
  logic signed [ES-1:0] serr, berr, db;
  logic [7:0]           cmd_s, cmd_b, cmd_a, cmd_z;
  logic [7:0]           addr_a, addr_z;
  logic                 snd_s, snd_b, snd_a, snd_z;

  function automatic logic [7:0] bang(input logic signed [ES-1:0] err,
                                      input logic signed [ES-1:0] dband,
                                      input logic [6:0] spd);
    logic [7:0] c;
    if (err < -dband) begin
      c = {1'b1, spd};
    end else if (err > dband) begin
      c = {1'b0, spd};
    end else begin
      c = 8'd0;
    end
    return c;
  endfunction

  assign fire       = vld_q && space_i;
  assign in_stall_o = vld_q && !fire;
  assign ld         = in_valid_i && !in_stall_o;
  assign vld_d      = ld || (vld_q && !fire);

  // quadrature decode, setpoint load, zero request
  always_comb begin
    trans   = {prev_q, enc_q};
    step_dn = trans inside {4'h1, 4'h7, 4'hE, 4'h8};
    step_up = trans inside {4'h2, 4'hB, 4'hD, 4'h4};

    cnt_d = cnt_q;
    if (step_dn && cnt_q != CNT_MIN) begin
      cnt_d = cnt_q - CW'(1);
    end else if (step_up && cnt_q != CNT_MAX) begin
      cnt_d = cnt_q + CW'(1);
    end

    slim = $signed({{(SW-15){1'b0}}, cfg_i.steer_limit});
    sv   = SW'(st_q);
    if (sv < -slim) sv = -slim;
    if (sv > slim) sv = slim;
    if (sv < SW'(CNT_MIN)) sv = SW'(CNT_MIN);
    if (sv > SW'(CNT_MAX)) sv = SW'(CNT_MAX);
    ssp_d = stv_q ? sv[CW-1:0] : ssp_q;

    bv = BW'(bt_q);
    if (bv < $signed({{(BW-10){1'b0}}, cfg_i.brake_min})) begin
      bv = $signed({{(BW-10){1'b0}}, cfg_i.brake_min});
    end
    if (bv > $signed({{(BW-10){1'b0}}, cfg_i.brake_max})) begin
      bv = $signed({{(BW-10){1'b0}}, cfg_i.brake_max});
    end
    if (bv > $signed({{(BW-PW){1'b0}}, POS_MAX})) begin
      bv = $signed({{(BW-PW){1'b0}}, POS_MAX});
    end
    bsp_d = btv_q ? bv[PW-1:0] : bsp_q;

    if (zero_q) begin
      cnt_d = '0;
      ssp_d = '0;
    end
  end

  // bang-bang control and change detect
  always_comb begin
    db    = $signed({{(ES-8){1'b0}}, cfg_i.deadband});
    serr  = ES'(ssp_d) - ES'(cnt_d);
    berr  = $signed({{(ES-PW){1'b0}}, bsp_d}) - $signed({{(ES-PW){1'b0}}, pos_q});
    cmd_s = estop_q ? 8'd0 : bang(serr, db, cfg_i.steer_rate);
    cmd_b = estop_q ? 8'd0 : bang(berr, db, cfg_i.brake_rate);
    snd_s = cfg_i.link_ready && (cmd_s != lcmd_q[sbac_pkg::CH_STEER]);
    snd_b = cfg_i.link_ready && (cmd_b != lcmd_q[sbac_pkg::CH_BRAKE]);

    // e-stop order is steer then brake; normal order is brake then steer
    if (estop_q) begin
      cmd_a = cmd_s;  snd_a = snd_s;  addr_a = sbac_pkg::STEER_ADDR;
      cmd_z = cmd_b;  snd_z = snd_b;  addr_z = sbac_pkg::BRAKE_ADDR;
    end else begin
      cmd_a = cmd_b;  snd_a = snd_b;  addr_a = sbac_pkg::BRAKE_ADDR;
      cmd_z = cmd_s;  snd_z = snd_s;  addr_z = sbac_pkg::STEER_ADDR;
    end

    push_o.p1 = sbac_pkg::mk_pkt(addr_z, cmd_z, 1'b1);
    if (snd_a) begin
      push_o.p0 = sbac_pkg::mk_pkt(addr_a, cmd_a, !snd_z);
    end else begin
      push_o.p0 = push_o.p1;
    end
    push_o.n = fire ? ({1'b0, snd_a} + {1'b0, snd_z}) : 2'd0;
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      enc_q   <= encoder_pins_i;
      pos_q   <= brake_position_i;
      estop_q <= estop_active_i;
      stv_q   <= steer_target_valid_i;
      st_q    <= steer_target_i;
      btv_q   <= brake_target_valid_i;
      bt_q    <= brake_target_i;
      zero_q  <= zero_steering_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      prev_q    <= '0;
      cnt_q     <= '0;
      ssp_q     <= '0;
      bsp_q     <= '0;
      lcmd_q[sbac_pkg::CH_STEER] <= '0;
      lcmd_q[sbac_pkg::CH_BRAKE] <= '0;
    end else begin
      vld_q <= vld_d;
      if (fire) begin
        prev_q <= enc_q;
        cnt_q  <= cnt_d;
        ssp_q  <= ssp_d;
        bsp_q  <= bsp_d;
        if (snd_s) lcmd_q[sbac_pkg::CH_STEER] <= cmd_s;
        if (snd_b) lcmd_q[sbac_pkg::CH_BRAKE] <= cmd_b;
      end
    end
  end

endmodule

/* hw/rtl/sbac_pktq.sv */
module sbac_pktq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbac_pkg::push_t push_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sbac_pkg::pkt_t  head_o
);

  localparam int AW = sbac_pkg::QAW;

  sbac_pkg::pkt_t mem [sbac_pkg::QDEPTH];
  logic [AW-1:0]  wp_q, wp_d, rp_q, rp_d, wp_nx;
  logic [AW:0]    cnt_q, cnt_d;
  logic           pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem[rp_q];
  // room for a full pair of packets
  assign space_o     = (cnt_q <= (AW+1)'(sbac_pkg::QDEPTH - 2));
  assign wp_nx       = wp_q + AW'(1);

  always_comb begin
    wp_d  = wp_q + AW'(push_i.n);
    rp_d  = pop ? (rp_q + AW'(1)) : rp_q;
    cnt_d = cnt_q + (AW+1)'(push_i.n) - (AW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem[wp_q] <= push_i.p0;
    if (push_i.n == 2'd2) mem[wp_nx] <= push_i.p1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hw/rtl/steer_brake_actuator_control.sv */
// Channel   Handshake                 Beat payload
// in        in_valid_i / in_stall_o   encoder pins, brake position, e-stop, targets, zero
// out       out_valid_o / out_stall_i one motor packet (address, dir, speed, checksum, last)
// cfg       cfg_we_i                  cfg_idx_i, cfg_wdata_i (write only)
//
// An input beat lands in the input register; once the queue has room for two
// packets, it is decoded, updates state and pushes 0..2 packets into a 4-entry
// packet queue, whose head drives the output.
// Items without packets flow at one per cycle while the queue has room for two packets;
// items with two packets are throttled by the single output port.
// Reset clears control state and config to defaults; no clearing pass is needed.
// in_stall_o rises only while the input register waits for 2 free queue slots.
module steer_brake_actuator_control #(
  parameter int COUNT_WIDTH    = sbac_pkg::COUNT_WIDTH_DEF,
  parameter int POSITION_WIDTH = sbac_pkg::POSITION_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [sbac_pkg::CFG_AW-1:0]  cfg_idx_i,
  input  logic [sbac_pkg::CFG_DW-1:0]  cfg_wdata_i,

  // input item channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   encoder_pins_i,
  input  logic [POSITION_WIDTH-1:0]    brake_position_i,
  input  logic                         estop_active_i,
  input  logic                         steer_target_valid_i,
  input  logic signed [15:0]           steer_target_i,
  input  logic                         brake_target_valid_i,
  input  logic signed [15:0]           brake_target_i,
  input  logic                         zero_steering_i,

  // motor packet channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   controller_address_o,
  output logic                         direction_o,
  output logic [6:0]                   speed_o,
  output logic [6:0]                   checksum_o,
  output logic                         last_packet_o
);

  sbac_pkg::cfg_t  cfg;
  sbac_pkg::push_t push;
  sbac_pkg::pkt_t  head;
  logic            space;

  // config register bank
  sbac_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register, encoder/setpoint state and bang-bang control
  sbac_core #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .encoder_pins_i       (encoder_pins_i),
    .brake_position_i     (brake_position_i),
    .estop_active_i       (estop_active_i),
    .steer_target_valid_i (steer_target_valid_i),
    .steer_target_i       (steer_target_i),
    .brake_target_valid_i (brake_target_valid_i),
    .brake_target_i       (brake_target_i),
    .zero_steering_i      (zero_steering_i),
    .space_i              (space),
    .push_o               (push)
  );

  // packet queue decouples result stalls from item intake
  sbac_pktq u_pktq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign controller_address_o = head.addr;
  assign direction_o          = head.dir;
  assign speed_o              = head.speed;
  assign checksum_o           = head.cks;
  assign last_packet_o        = head.last;

endmodule

/* tb/sbac_checker.sv */
module sbac_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [sbac_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  logic [sbac_pkg::CFG_DW-1:0]   cfg_wdata_i,

  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    encoder_pins_i,
  input  logic [9:0]                    brake_position_i,
  input  logic                          estop_active_i,
  input  logic                          steer_target_valid_i,
  input  logic signed [15:0]            steer_target_i,
  input  logic                          brake_target_valid_i,
  input  logic signed [15:0]            brake_target_i,
  input  logic                          zero_steering_i,

  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [7:0]                    controller_address_i,
  input  logic                          direction_i,
  input  logic [6:0]                    speed_i,
  input  logic [6:0]                    checksum_i,
  input  logic                          last_packet_i,

  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int CNT_MAX    = (1 << (sbac_pkg::COUNT_WIDTH_DEF - 1)) - 1;
  localparam int CNT_MIN    = -(1 << (sbac_pkg::COUNT_WIDTH_DEF - 1));
  localparam int POS_MAX    = (1 << sbac_pkg::POSITION_WIDTH_DEF) - 1;

  sbac_pkg::cfg_t     cfg;
  logic [1:0]         prev_pins;
  logic signed [15:0] steer_cnt;
  logic signed [15:0] steer_sp;
  logic [9:0]         brake_sp;
  logic [7:0]         last_cmd [2];
  sbac_pkg::pkt_t     packet_q [$];
  int                 fail_cnt = 0;
  int                 pend = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pend;

  function automatic int enc_step(logic [1:0] from, logic [1:0] to);
    case ({from, to})
      4'h1, 4'h7, 4'hE, 4'h8: return -1;
      4'h2, 4'hB, 4'hD, 4'h4: return 1;
      default:                return 0;
    endcase
  endfunction

  // {dir, speed}; negative error drives dir 1 on both channels
  function automatic logic [7:0] bang_cmd(int err, logic [6:0] spd);
    int db;
    db = int'(cfg.deadband);
    if (err < -db) return {1'b1, spd};
    if (err > db)  return {1'b0, spd};
    return 8'h00;
  endfunction

  function automatic void issue(int ch, logic [7:0] cmd);
    sbac_pkg::pkt_t p;
    logic [7:0]     addr;
    if (!cfg.link_ready || last_cmd[ch] == cmd) return;
    last_cmd[ch] = cmd;
    addr    = (ch == sbac_pkg::CH_BRAKE) ? sbac_pkg::BRAKE_ADDR : sbac_pkg::STEER_ADDR;
    p.addr  = addr;
    p.dir   = cmd[7];
    p.speed = cmd[6:0];
    p.cks   = 7'(int'(addr) + int'(cmd[7]) + int'(cmd[6:0]));
    p.last  = 1'b0;
    packet_q.push_back(p);
  endfunction

  task automatic predict_beat();
    int cnt;
    int v;
    int n0;
    n0  = packet_q.size();
    cnt = int'(steer_cnt) + enc_step(prev_pins, encoder_pins_i);
    if (cnt > CNT_MAX) cnt = CNT_MAX;
    if (cnt < CNT_MIN) cnt = CNT_MIN;
    steer_cnt = 16'(cnt);
    prev_pins = encoder_pins_i;

    if (steer_target_valid_i) begin
      v = int'(steer_target_i);
      if (v < -int'(cfg.steer_limit)) v = -int'(cfg.steer_limit);
      if (v > int'(cfg.steer_limit))  v = int'(cfg.steer_limit);
      if (v < CNT_MIN) v = CNT_MIN;
      if (v > CNT_MAX) v = CNT_MAX;
      steer_sp = 16'(v);
    end
    if (brake_target_valid_i) begin
      v = int'(brake_target_i);
      if (v < int'(cfg.brake_min)) v = int'(cfg.brake_min);
      if (v > int'(cfg.brake_max)) v = int'(cfg.brake_max);
      if (v < 0)       v = 0;
      if (v > POS_MAX) v = POS_MAX;
      brake_sp = 10'(v);
    end
    if (zero_steering_i) begin
      steer_cnt = '0;
      steer_sp  = '0;
    end

    if (estop_active_i) begin
      issue(sbac_pkg::CH_STEER, 8'h00);
      issue(sbac_pkg::CH_BRAKE, 8'h00);
    end else begin
      issue(sbac_pkg::CH_BRAKE,
            bang_cmd(int'(brake_sp) - int'(brake_position_i), cfg.brake_rate));
      issue(sbac_pkg::CH_STEER,
            bang_cmd(int'(steer_sp) - int'(steer_cnt), cfg.steer_rate));
    end
    if (packet_q.size() > n0) packet_q[packet_q.size() - 1].last = 1'b1;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  task automatic check_packet();
    sbac_pkg::pkt_t want;
    if (packet_q.size() == 0) begin
      $display("%0t: packet mismatch, expected none, actual addr %0d dir %0d speed %0d",
               $time, controller_address_i, direction_i, speed_i);
      fail_cnt++;
      return;
    end
    want = packet_q.pop_front();
    check_field("address",  want.addr,          controller_address_i);
    check_field("direction", 8'(want.dir),      8'(direction_i));
    check_field("speed",    8'(want.speed),     8'(speed_i));
    check_field("checksum", 8'(want.cks),       8'(checksum_i));
    check_field("last",     8'(want.last),      8'(last_packet_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.link_ready  = sbac_pkg::RST_LINK_READY;
      cfg.deadband    = sbac_pkg::RST_DEADBAND;
      cfg.steer_rate  = sbac_pkg::RST_STEER_RATE;
      cfg.brake_rate  = sbac_pkg::RST_BRAKE_RATE;
      cfg.steer_limit = sbac_pkg::RST_STEER_LIMIT;
      cfg.brake_min   = sbac_pkg::RST_BRAKE_MIN;
      cfg.brake_max   = sbac_pkg::RST_BRAKE_MAX;
      prev_pins   = '0;
      steer_cnt   = '0;
      steer_sp    = '0;
      brake_sp    = '0;
      last_cmd[0] = '0;
      last_cmd[1] = '0;
      packet_q.delete();
      pend = 0;
    end else begin
      if (cfg_we_i) begin
        case (sbac_pkg::cfg_idx_e'(cfg_idx_i))
          sbac_pkg::CFG_LINK_READY:  cfg.link_ready  = cfg_wdata_i[0];
          sbac_pkg::CFG_DEADBAND:    cfg.deadband    = cfg_wdata_i[7:0];
          sbac_pkg::CFG_STEER_RATE:  cfg.steer_rate  = cfg_wdata_i[6:0];
          sbac_pkg::CFG_BRAKE_RATE:  cfg.brake_rate  = cfg_wdata_i[6:0];
          sbac_pkg::CFG_STEER_LIMIT: cfg.steer_limit = cfg_wdata_i[14:0];
          sbac_pkg::CFG_BRAKE_MIN:   cfg.brake_min   = cfg_wdata_i[9:0];
          sbac_pkg::CFG_BRAKE_MAX:   cfg.brake_max   = cfg_wdata_i[9:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_packet();
      if (in_valid_i && !in_stall_i)   predict_beat();
      pend = packet_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;

  // run length and pacing
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 6;     // beat sits in the input reg, then is pushed to the queue
  localparam int HOLD_CYCLES  = 120;   // long receiver hold-off, fills the 4-deep queue
  localparam int SEG_ITEMS    = 180;
  localparam int NUM_SEGS     = 6;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;

  sbac_pkg::cfg_idx_e  cfg_idx = sbac_pkg::CFG_LINK_READY;
  logic                cfg_we = 1'b0;
  logic [sbac_pkg::CFG_DW-1:0] cfg_wdata = '0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          enc_pins = '0;
  logic [9:0]          brake_pos = '0;
  logic                estop = 1'b0;
  logic                steer_tgt_vld = 1'b0;
  logic [15:0]         steer_tgt = '0;
  logic                brake_tgt_vld = 1'b0;
  logic [15:0]         brake_tgt = '0;
  logic                zero_req = 1'b0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          ctl_addr;
  logic                pkt_dir;
  logic [6:0]          pkt_speed;
  logic [6:0]          pkt_cks;
  logic                pkt_last;

  int                  fail_count;
  int                  pending;

  // pacing knobs, percent of cycles spent idle on each side
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  // hold-off requests: bumped by the stimulus, tracked by the receiver
  int                  hold_seq = 0;
  int                  hold_seen = 0;

  // stimulus-side tracking: pins last sent, brake level to sample around
  logic [1:0]          cur_pins = '0;
  logic [9:0]          brake_ref = 10'd500;
  int                  cycle_cnt = 0;
  sbac_pkg::cfg_t      c;

  always #5 clk_i = ~clk_i;

  steer_brake_actuator_control u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_wdata_i          (cfg_wdata),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .encoder_pins_i       (enc_pins),
    .brake_position_i     (brake_pos),
    .estop_active_i       (estop),
    .steer_target_valid_i (steer_tgt_vld),
    .steer_target_i       (steer_tgt),
    .brake_target_valid_i (brake_tgt_vld),
    .brake_target_i       (brake_tgt),
    .zero_steering_i      (zero_req),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .controller_address_o (ctl_addr),
    .direction_o          (pkt_dir),
    .speed_o              (pkt_speed),
    .checksum_o           (pkt_cks),
    .last_packet_o        (pkt_last)
  );

  // checker sits beside the block and watches both channels plus config writes
  sbac_checker u_check (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_wdata_i          (cfg_wdata),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall),
    .encoder_pins_i       (enc_pins),
    .brake_position_i     (brake_pos),
    .estop_active_i       (estop),
    .steer_target_valid_i (steer_tgt_vld),
    .steer_target_i       (steer_tgt),
    .brake_target_valid_i (brake_tgt_vld),
    .brake_target_i       (brake_tgt),
    .zero_steering_i      (zero_req),
    .out_valid_i          (out_valid),
    .out_stall_i          (out_stall),
    .controller_address_i (ctl_addr),
    .direction_i          (pkt_dir),
    .speed_i              (pkt_speed),
    .checksum_i           (pkt_cks),
    .last_packet_i        (pkt_last),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall per cycle, or a long hold-off when asked.
  // The hold-off is counted here so the sender keeps offering beats meanwhile.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // One quadrature step either way: up = count increment.
  function automatic logic [1:0] next_pins(logic [1:0] p, bit up);
    case (p)
      2'd0:    return up ? 2'd2 : 2'd1;
      2'd1:    return up ? 2'd0 : 2'd3;
      2'd2:    return up ? 2'd3 : 2'd0;
      default: return up ? 2'd1 : 2'd2;
    endcase
  endfunction

  function automatic sbac_pkg::cfg_t reset_cfg();
    sbac_pkg::cfg_t r;
    r.link_ready  = sbac_pkg::RST_LINK_READY;
    r.deadband    = sbac_pkg::RST_DEADBAND;
    r.steer_rate  = sbac_pkg::RST_STEER_RATE;
    r.brake_rate  = sbac_pkg::RST_BRAKE_RATE;
    r.steer_limit = sbac_pkg::RST_STEER_LIMIT;
    r.brake_min   = sbac_pkg::RST_BRAKE_MIN;
    r.brake_max   = sbac_pkg::RST_BRAKE_MAX;
    return r;
  endfunction

  // Writes every register back to back; we stays high across the burst.
  task automatic load_config(input sbac_pkg::cfg_t v);
    sbac_pkg::cfg_idx_e idx;
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we  <= 1'b1;
      cfg_idx <= idx;
      case (idx)
        sbac_pkg::CFG_LINK_READY:  cfg_wdata <= {14'd0, v.link_ready};
        sbac_pkg::CFG_DEADBAND:    cfg_wdata <= {7'd0, v.deadband};
        sbac_pkg::CFG_STEER_RATE:  cfg_wdata <= {8'd0, v.steer_rate};
        sbac_pkg::CFG_BRAKE_RATE:  cfg_wdata <= {8'd0, v.brake_rate};
        sbac_pkg::CFG_STEER_LIMIT: cfg_wdata <= v.steer_limit;
        sbac_pkg::CFG_BRAKE_MIN:   cfg_wdata <= {5'd0, v.brake_min};
        default:                   cfg_wdata <= {5'd0, v.brake_max};
      endcase
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one beat, with an optional random gap first; returns once accepted.
  // valid is only dropped when a gap follows, so it never toggles within a step.
  task automatic send_beat(input logic [1:0] pins, input logic [9:0] pos,
                           input logic stop, input logic stv, input logic [15:0] st,
                           input logic btv, input logic [15:0] bt, input logic zero);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    enc_pins      <= pins;
    brake_pos     <= pos;
    estop         <= stop;
    steer_tgt_vld <= stv;
    steer_tgt     <= st;
    brake_tgt_vld <= btv;
    brake_tgt     <= bt;
    zero_req      <= zero;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    cur_pins = pins;
  endtask

  // Sender pause: no beat offered until every expected packet is back,
  // then DRAIN_CYCLES more so a beat that makes no packet can clear the pipe.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random beat. Mostly clean encoder steps, steer targets near zero and brake
  // positions near the last brake target so the deadband edges get hit; the rest is noise.
  task automatic rand_beat();
    logic [1:0]  pins;
    logic [9:0]  pos;
    logic        stv;
    logic        btv;
    logic [15:0] st;
    logic [15:0] bt;
    int          r;
    int          p;
    r = $urandom_range(99);
    if (r < 45)      pins = next_pins(cur_pins, 1'b1);
    else if (r < 90) pins = next_pins(cur_pins, 1'b0);
    else if (r < 95) pins = cur_pins;
    else             pins = ~cur_pins;                  // double step, ignored

    stv = ($urandom_range(99) < 30);
    r = $urandom_range(99);
    if (r < 60)      st = 16'(int'($urandom_range(80)) - 40);
    else if (r < 85) st = 16'($urandom);
    else if (r < 93) st = 16'h7FFF;
    else             st = 16'h8000;

    btv = ($urandom_range(99) < 25);
    r = $urandom_range(99);
    if (r < 70)      bt = 16'($urandom_range(1023));
    else if (r < 90) bt = 16'($urandom);
    else if (r < 95) bt = 16'h7FFF;
    else             bt = 16'h8000;
    if (btv && bt < 16'd1024) brake_ref = bt[9:0];

    if ($urandom_range(99) < 70) begin
      p = int'(brake_ref) + int'($urandom_range(80)) - 40;
      if (p < 0)    p = 0;
      if (p > 1023) p = 1023;
      pos = 10'(p);
    end else begin
      pos = 10'($urandom);
    end

    send_beat(pins, pos, $urandom_range(99) < 6, stv, st, btv, bt,
              $urandom_range(99) < 4);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 15;
    recv_idle_pct = 68;

    // --- directed ---
    // link still down after reset: state moves, no packets
    send_beat(2'd1, 10'd0, 1'b0, 1'b0, 16'd0, 1'b1, 16'd500, 1'b0);
    wait_quiet();
    c = reset_cfg();
    c.link_ready = 1'b1;
    load_config(c);

    // decrement ring, brake swings either side of setpoint 500
    send_beat(2'd3, 10'd1023, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    send_beat(2'd2, 10'd0,    1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    send_beat(2'd0, 10'd500,  1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    // increment ring
    send_beat(2'd2, 10'd500, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    send_beat(2'd3, 10'd500, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    send_beat(2'd1, 10'd500, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    send_beat(2'd0, 10'd500, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    // both pins flip twice, then no change
    send_beat(2'd3, 10'd500, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    send_beat(2'd0, 10'd500, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    send_beat(2'd0, 10'd500, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    // steer targets at the field extremes, clamped to the limit
    send_beat(2'd0, 10'd500, 1'b0, 1'b1, 16'h7FFF, 1'b0, 16'd0, 1'b0);
    send_beat(2'd0, 10'd500, 1'b0, 1'b1, 16'h8000, 1'b0, 16'd0, 1'b0);
    // brake targets at the extremes: raised to min, lowered to max
    send_beat(2'd0, 10'd1023, 1'b0, 1'b0, 16'd0, 1'b1, 16'h8000, 1'b0);
    send_beat(2'd0, 10'd0,    1'b0, 1'b0, 16'd0, 1'b1, 16'h7FFF, 1'b0);
    // e-stop with both motors running: two stop packets, then none
    send_beat(2'd0, 10'd0, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    send_beat(2'd0, 10'd0, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    // zero request beats a steer target in the same beat
    send_beat(2'd0, 10'd0, 1'b0, 1'b1, 16'd1000, 1'b0, 16'd0, 1'b1);
    // brake deadband edges around 512
    send_beat(2'd0, 10'd512, 1'b0, 1'b0, 16'd0, 1'b1, 16'd512, 1'b0);
    send_beat(2'd0, 10'd532, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    send_beat(2'd0, 10'd533, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    send_beat(2'd0, 10'd491, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
    // steer deadband edges, count at zero
    send_beat(2'd0, 10'd512, 1'b0, 1'b1, 16'd21, 1'b0, 16'd0, 1'b0);
    send_beat(2'd0, 10'd512, 1'b0, 1'b1, 16'hFFEC, 1'b0, 16'd0, 1'b0);
    send_beat(2'd0, 10'd512, 1'b0, 1'b1, 16'hFFEB, 1'b0, 16'd0, 1'b0);
    wait_quiet();

    // --- random segments: two per pacing phase, new register set each ---
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      c = reset_cfg();
      c.link_ready = 1'b1;
      case (seg)
        1: begin                           // everything wide open
          c.deadband    = 8'd0;
          c.steer_rate  = 7'd127;
          c.brake_rate  = 7'd127;
          c.steer_limit = 15'h7FFF;
          c.brake_min   = 10'd0;
          c.brake_max   = 10'd1023;
        end
        2: begin                           // everything shut, min above max
          c.deadband    = 8'd255;
          c.steer_rate  = 7'd0;
          c.brake_rate  = 7'd0;
          c.steer_limit = 15'd0;
          c.brake_min   = 10'd1023;
          c.brake_max   = 10'd0;
        end
        3, 5: begin                        // link drops in 3; command memory persists
          c.link_ready  = (seg == 5);
          c.deadband    = 8'($urandom_range(40));
          c.steer_rate  = 7'($urandom);
          c.brake_rate  = 7'($urandom);
          c.steer_limit = 15'($urandom);
          c.brake_min   = 10'($urandom);
          c.brake_max   = 10'($urandom);
        end
        default: ;
      endcase
      load_config(c);

      // long receiver hold-off while beats keep coming: queue fills, input stalls
      if (seg % 2 == 0) hold_seq <= hold_seq + 1;
      repeat (SEG_ITEMS) rand_beat();
      wait_quiet();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
